@@ sv/lesm_pkg.sv @@
// Shared types, constants and helpers for the largest-empty-square map core.
// No dependencies; imported by the interfaces, the position tracker, the core and the checker.
`default_nettype none

package lesm_pkg;

  // Grid limits
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  // Counter and dimension widths follow from the grid limits
  localparam int unsigned COL_W   = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W   = $clog2(MAX_HEIGHT);
  localparam int unsigned W_DIM_W = COL_W + 1;
  localparam int unsigned H_DIM_W = ROW_W + 1;

  // Fixed field widths
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned SIDE_W    = 11;

  localparam logic [SIDE_W-1:0] SIDE_MAX = {SIDE_W{1'b1}};

  // Compare widths for clamping a register value against a limit
  localparam int unsigned W_CMP_W = (CFG_W > W_DIM_W) ? CFG_W : W_DIM_W;
  localparam int unsigned H_CMP_W = (CFG_W > H_DIM_W) ? CFG_W : H_DIM_W;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(MAX_HEIGHT);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_e;

  // Position of the cell being accepted, from the position tracker
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             bottom_row;
    logic             frame_end;
  } cell_pos_t;

  // Register value clamped to 1..MAX_WIDTH
  function automatic logic [W_DIM_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
    logic [W_CMP_W-1:0] ext;
    logic [W_DIM_W-1:0] res;
    ext = W_CMP_W'(v);
    if (ext == '0) begin
      res = W_DIM_W'(1);
    end else if (ext > W_CMP_W'(MAX_WIDTH)) begin
      res = W_DIM_W'(MAX_WIDTH);
    end else begin
      res = W_DIM_W'(ext);
    end
    return res;
  endfunction

  // Register value clamped to 1..MAX_HEIGHT
  function automatic logic [H_DIM_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
    logic [H_CMP_W-1:0] ext;
    logic [H_DIM_W-1:0] res;
    ext = H_CMP_W'(v);
    if (ext == '0) begin
      res = H_DIM_W'(1);
    end else if (ext > H_CMP_W'(MAX_HEIGHT)) begin
      res = H_DIM_W'(MAX_HEIGHT);
    end else begin
      res = H_DIM_W'(ext);
    end
    return res;
  endfunction

  // Three-way minimum
  function automatic logic [SIDE_W-1:0] min3(input logic [SIDE_W-1:0] a,
                                             input logic [SIDE_W-1:0] b,
                                             input logic [SIDE_W-1:0] c);
    logic [SIDE_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

`default_nettype wire

@@ sv/lesm_intf.sv @@
// Handshake channel interfaces of the largest-empty-square map core:
// cell input, result output and configuration write. Depends on lesm_pkg.
`default_nettype none

interface lesm_cell_if;
  import lesm_pkg::*;
  logic valid;
  logic ready;
  logic blocked;
  modport source (output valid, output blocked, input ready);
  modport sink   (input valid, input blocked, output ready);
endinterface

interface lesm_result_if;
  import lesm_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIDE_W-1:0] square_side;
  logic              frame_end;
  modport source (output valid, output square_side, output frame_end, input ready);
  modport sink   (input valid, input square_side, input frame_end, output ready);
endinterface

interface lesm_cfg_if;
  import lesm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/lesm_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module lesm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/lesm_pos.sv @@
// Column/row tracker: gives the grid position of the cell being accepted and
// advances on each transfer. Depends on lesm_pkg.
`default_nettype none

module lesm_pos
  import lesm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               advance_i,
  input  wire logic [W_DIM_W-1:0] width_i,
  input  wire logic [H_DIM_W-1:0] height_i,
  output cell_pos_t               pos_o
);

  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic               col_wrap;
  logic [COL_W-1:0]   col_cur;
  logic [H_DIM_W-1:0] row_step;
  logic [ROW_W-1:0]   row_cur;
  logic [W_DIM_W-1:0] col_inc;
  logic [H_DIM_W-1:0] row_inc;
  logic               last_col;
  logic               last_row;

  // Wrap counters left beyond a size that shrank mid-frame
  always_comb begin
    col_wrap = W_DIM_W'(col_q) >= width_i;
    col_cur  = col_wrap ? '0 : col_q;
    row_step = col_wrap ? H_DIM_W'(row_q) + H_DIM_W'(1) : H_DIM_W'(row_q);
    row_cur  = (row_step >= height_i) ? '0 : row_step[ROW_W-1:0];
  end

  // End of row / end of frame
  always_comb begin
    col_inc  = W_DIM_W'(col_cur) + W_DIM_W'(1);
    row_inc  = H_DIM_W'(row_cur) + H_DIM_W'(1);
    last_col = col_inc >= width_i;
    last_row = row_inc >= height_i;
  end

  // Next position
  always_comb begin
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_d = col_inc[COL_W-1:0];
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (advance_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign pos_o.col        = col_cur;
  assign pos_o.bottom_row = (row_cur == '0);
  assign pos_o.frame_end  = last_col & last_row;

endmodule

`default_nettype wire

@@ sv/largest_empty_square_map_core.sv @@
// Largest-empty-square map core: per cell, side of the largest free square
// with that cell as its top-left corner. Depends on lesm_pkg, lesm_intf,
// lesm_pos and lesm_ram.
//
// Usage:
//   cell_i   : one grid cell per transfer (blocked = 1 for an obstacle), bottom
//              row first, each row right to left.
//   result_o : one result per cell, in order; frame_end marks the last cell.
//   cfg_i    : register writes (index 0 = row width, 1 = row count), always
//              ready; write only while no cell is in flight.
// Throughput: one cell per cycle while result_o drains. A cell passes through
// the input register, then the result register, to result valid; the line-store
// read issued at the cell transfer lands with the cell in the input register.
// Reset: counters, pipeline valids and the neighbor registers clear; both
// size registers return to 1024. The line store is not cleared: the bottom
// row ignores what it reads.
// Stall: a held result keeps its value; one more cell can sit in the input
// register behind it, after which cell_i.ready drops until result_o drains.
`default_nettype none

module largest_empty_square_map_core
  import lesm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  lesm_cell_if.sink     cell_i,
  lesm_result_if.source result_o,
  lesm_cfg_if.sink      cfg_i
);

  // Configuration registers
  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;

  // Input stage
  logic             s1_valid_q;
  logic             s1_blocked_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_bottom_q;
  logic             s1_fend_q;
  logic             fwd_q;
  logic [SIDE_W-1:0] fwd_data_q;

  // Neighbor registers
  logic [SIDE_W-1:0] right_q;
  logic [SIDE_W-1:0] diag_q;

  // Result stage
  logic              out_valid_q;
  logic [SIDE_W-1:0] out_side_q;
  logic              out_fend_q;

  logic              cell_xfer;
  logic              s1_adv;
  cell_pos_t         pos;
  logic [SIDE_W-1:0] rd_data;
  logic [SIDE_W-1:0] below;
  logic [SIDE_W-1:0] right_n;
  logic [SIDE_W-1:0] diag_n;
  logic [SIDE_W:0]   side_sum;
  logic [SIDE_W-1:0] side;

  // Configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        CFG_WIDTH:  width_q  <= cfg_i.data;
        CFG_HEIGHT: height_q <= cfg_i.data;
        default:    ;
      endcase
    end
  end

  // Handshake
  assign s1_adv       = s1_valid_q & (~out_valid_q | result_o.ready);
  assign cell_i.ready = ~s1_valid_q | s1_adv;
  assign cell_xfer    = cell_i.valid & cell_i.ready;

  // Position of the incoming cell
  lesm_pos u_pos (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (cell_xfer),
    .width_i   (clamp_width(width_q)),
    .height_i  (clamp_height(height_q)),
    .pos_o     (pos)
  );

  // Line store holding the row below
  lesm_ram #(
    .WIDTH (SIDE_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (side),
    .re_i    (cell_xfer),
    .raddr_i (pos.col),
    .rdata_o (rd_data)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (cell_i.ready) begin
      s1_valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_xfer) begin
      s1_blocked_q <= cell_i.blocked;
      s1_col_q     <= pos.col;
      s1_bottom_q  <= pos.bottom_row;
      s1_fend_q    <= pos.frame_end;
      // same entry written this edge: take the new value, not the stale read
      fwd_q        <= s1_adv & (s1_col_q == pos.col);
      fwd_data_q   <= side;
    end
  end

  // Cell result: 0 if blocked, else 1 + min of the three neighbors
  always_comb begin
    below    = s1_bottom_q ? '0 : (fwd_q ? fwd_data_q : rd_data);
    right_n  = (s1_col_q == '0) ? '0 : right_q;
    diag_n   = (s1_col_q == '0) ? '0 : diag_q;
    side_sum = (SIDE_W+1)'(min3(right_n, below, diag_n)) + (SIDE_W+1)'(1);
    if (s1_blocked_q) begin
      side = '0;
    end else if (side_sum[SIDE_W]) begin
      side = SIDE_MAX;
    end else begin
      side = side_sum[SIDE_W-1:0];
    end
  end

  // Neighbor registers advance with each retired cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q <= '0;
      diag_q  <= '0;
    end else if (s1_adv) begin
      right_q <= side;
      diag_q  <= below;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_side_q <= side;
      out_fend_q <= s1_fend_q;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.square_side = out_side_q;
  assign result_o.frame_end   = out_fend_q;

endmodule

`default_nettype wire

@@ sv/lesm_checker.sv @@
// Port-level checks for the largest-empty-square map core, bound to the top
// level. Depends on lesm_pkg and largest_empty_square_map_core.
`default_nettype none

module lesm_checker
  import lesm_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_i,
  input wire logic              in_blocked_i,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [SIDE_W-1:0] out_side_i,
  input wire logic              out_fend_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i & in_ready_i;

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_side_i) && $stable(out_fend_i))
    else $error("stalled result changed");

  // Nothing valid out of reset
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // With the output draining, a transferred cell shows as a valid result; zero iff blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer ##1 out_ready_i |=>
      out_valid_i && ((out_side_i == '0) == $past(in_blocked_i, 2)))
    else $error("cell result missing or wrong for blocked flag");

  // A square never exceeds the maximum grid width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_side_i <= SIDE_W'(MAX_WIDTH))
    else $error("square side beyond grid width");

endmodule

bind largest_empty_square_map_core lesm_checker u_lesm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (cell_i.valid),
  .in_ready_i   (cell_i.ready),
  .in_blocked_i (cell_i.blocked),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .out_side_i   (result_o.square_side),
  .out_fend_i   (result_o.frame_end)
);

`default_nettype wire
